[sv/csrm_pkg.sv]
// ----------------------------------------------------------------------------
// csrm_pkg: crossing stop recovery mode shared definitions
// Request and mode codes, register indexes, reset values and the structs that
// pass between the configuration bank, the state update and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package csrm_pkg;

  // request kinds
  localparam logic [2:0] REQ_MAP    = 3'd0;
  localparam logic [2:0] REQ_SPEED  = 3'd1;
  localparam logic [2:0] REQ_LIGHTS = 3'd2;
  localparam logic [2:0] REQ_TICK   = 3'd3;
  localparam logic [2:0] REQ_DECIDE = 3'd4;

  // drive modes
  localparam logic [2:0] MODE_FOLLOW = 3'd0;
  localparam logic [2:0] MODE_HOLD   = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_CROSS_AREA   = 3'd0;
  localparam logic [2:0] CFG_RED_CODE     = 3'd1;
  localparam logic [2:0] CFG_RECOVER_INIT = 3'd2;
  localparam logic [2:0] CFG_RECOVER_WAIT = 3'd3;
  localparam logic [2:0] CFG_CONSTR_LIMIT = 3'd4;
  localparam logic [2:0] CFG_STOP_SPEED   = 3'd5;

  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [19:0] RST_CROSS_AREA   = 20'd400;
  localparam logic [7:0]  RST_RED_CODE     = 8'd1;
  localparam logic        RST_RECOVER_INIT = 1'b0;
  localparam logic [15:0] RST_RECOVER_WAIT = 16'd100;
  localparam logic [15:0] RST_CONSTR_LIMIT = 16'd600;
  localparam logic [14:0] RST_STOP_SPEED   = 15'd200;

  // turn directions
  localparam logic [1:0] TURN_STRAIGHT = 2'd0;
  localparam logic [1:0] TURN_LEFT     = 2'd1;
  localparam logic [1:0] TURN_RIGHT    = 2'd2;

  localparam logic [15:0] TICK_MAX = 16'hffff;

  typedef struct packed {
    logic [19:0] cross_area_dm;
    logic [7:0]  red_code;
    logic [15:0] recover_wait_ticks;
    logic [15:0] construction_limit;
    logic [14:0] stop_speed_cq;
  } cfg_t;

  // writing recover_initial only loads the recovered flag
  typedef struct packed {
    logic load;
    logic value;
  } rec_load_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [19:0]        distance_dm;
    logic [7:0]         lane_flag;
    logic [7:0]         crossing_kind;
    logic signed [15:0] speed_cq;
    logic [7:0]         left_color;
    logic [7:0]         forward_color;
    logic [7:0]         right_color;
  } item_t;

endpackage

`default_nettype wire

[sv/crossing_stop_recovery_mode_unit.sv]
// ----------------------------------------------------------------------------
// crossing_stop_recovery_mode_unit: vehicle mode supervisor top level
// Takes map, speed, light, tick and decide transactions and returns a drive
// mode for each decide transaction.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type .. right_color
//   out      output     out_valid / out_ready drive_mode
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One transaction per cycle while in_ready is high: the state update is one pass of logic between
// the accepted fields and the state and result registers.
// A decide result shows on out in the cycle after acceptance.
// in_ready drops only while a result waits and out_ready is low.
// Reset (rst, synchronous) restores all registers and state but drive_mode to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crossing_stop_recovery_mode_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      req_type,
  input  wire logic [19:0]                     distance_dm,
  input  wire logic [7:0]                      lane_flag,
  input  wire logic [7:0]                      crossing_kind,
  input  wire logic signed [15:0]              speed_cq,
  input  wire logic [7:0]                      left_color,
  input  wire logic [7:0]                      forward_color,
  input  wire logic [7:0]                      right_color,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           drive_mode,
  input  wire logic                            cfg_we,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [csrm_pkg::CFG_DATA_W-1:0] cfg_data
);

  csrm_pkg::cfg_t      cfg;
  csrm_pkg::rec_load_t rec_load;
  csrm_pkg::item_t     item;
  logic                take;
  logic [2:0]          mode_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    item.req_type      = req_type;
    item.distance_dm   = distance_dm;
    item.lane_flag     = lane_flag;
    item.crossing_kind = crossing_kind;
    item.speed_cq      = speed_cq;
    item.left_color    = left_color;
    item.forward_color = forward_color;
    item.right_color   = right_color;
  end

  csrm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .rec_load (rec_load)
  );

  csrm_state u_state (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .cfg      (cfg),
    .rec_load (rec_load),
    .mode_next(mode_next)
  );

  // result register: load on a decide transaction, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && req_type == csrm_pkg::REQ_DECIDE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req_type == csrm_pkg::REQ_DECIDE) begin
      drive_mode <= mode_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_mode == csrm_pkg::MODE_FOLLOW ||
                   drive_mode == csrm_pkg::MODE_HOLD))
    else $error("drive mode outside the produced codes");

  assert property (@(posedge clk) disable iff (rst)
    (take && req_type == csrm_pkg::REQ_DECIDE) |=> out_valid)
    else $error("decide transaction produced no result");

  assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(take && req_type == csrm_pkg::REQ_DECIDE)) |=> !out_valid)
    else $error("result appeared without a decide transaction");

  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

[sv/csrm_cfg.sv]
// ----------------------------------------------------------------------------
// csrm_cfg: configuration register bank
// Holds the settings; a write to recover_initial reloads recovered.
// ----------------------------------------------------------------------------
`default_nettype none

module csrm_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [csrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output csrm_pkg::cfg_t                         cfg,
  output csrm_pkg::rec_load_t                    rec_load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cross_area_dm      <= csrm_pkg::RST_CROSS_AREA;
      cfg.red_code           <= csrm_pkg::RST_RED_CODE;
      cfg.recover_wait_ticks <= csrm_pkg::RST_RECOVER_WAIT;
      cfg.construction_limit <= csrm_pkg::RST_CONSTR_LIMIT;
      cfg.stop_speed_cq      <= csrm_pkg::RST_STOP_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        csrm_pkg::CFG_CROSS_AREA:   cfg.cross_area_dm      <= cfg_data[19:0];
        csrm_pkg::CFG_RED_CODE:     cfg.red_code           <= cfg_data[7:0];
        // recover_initial only reloads recovered through rec_load
        csrm_pkg::CFG_RECOVER_INIT: ;
        csrm_pkg::CFG_RECOVER_WAIT: cfg.recover_wait_ticks <= cfg_data[15:0];
        csrm_pkg::CFG_CONSTR_LIMIT: cfg.construction_limit <= cfg_data[15:0];
        csrm_pkg::CFG_STOP_SPEED:   cfg.stop_speed_cq      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rec_load.load  = cfg_we && (cfg_index == csrm_pkg::CFG_RECOVER_INIT);
    rec_load.value = cfg_data[0];
  end

endmodule

`default_nettype wire

[sv/csrm_state.sv]
// ----------------------------------------------------------------------------
// csrm_state: supervisor state and single-pass update
// Applies one accepted transaction to the flags and counters and forms the
// drive mode for a decide request.
// ----------------------------------------------------------------------------
`default_nettype none

module csrm_state (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  csrm_pkg::item_t          item,
  input  csrm_pkg::cfg_t           cfg,
  input  csrm_pkg::rec_load_t      rec_load,
  output logic [2:0]               mode_next
);

  logic               near_crossing, near_crossing_next;
  logic               at_pedestrian, at_pedestrian_next;
  logic               light_controlled, light_controlled_next;
  logic [1:0]         turn_dir, turn_dir_next;
  logic               in_construction, in_construction_next;
  logic [15:0]        construction_ticks, construction_ticks_next;
  logic [15:0]        stop_ticks, stop_ticks_next;
  logic               recovered, recovered_next;
  logic [2:0]         last_mode, last_mode_next;
  logic signed [15:0] speed_now, speed_now_next;
  logic [2:0]         lights_go, lights_go_next;

  logic [16:0] speed_mag;
  logic        red_ahead;
  logic        stopped_ok;
  logic [15:0] stop_inc;
  logic        zone_hit;

  always_comb begin
    near_crossing_next      = near_crossing;
    at_pedestrian_next      = at_pedestrian;
    light_controlled_next   = light_controlled;
    turn_dir_next           = turn_dir;
    in_construction_next    = in_construction;
    construction_ticks_next = construction_ticks;
    stop_ticks_next         = stop_ticks;
    recovered_next          = recovered;
    last_mode_next          = last_mode;
    speed_now_next          = speed_now;
    lights_go_next          = lights_go;
    mode_next               = csrm_pkg::MODE_FOLLOW;
    stop_inc                = stop_ticks;

    speed_mag = speed_now[15] ? (17'd0 - {speed_now[15], speed_now})
                              : {1'b0, speed_now};

    case (turn_dir)
      csrm_pkg::TURN_STRAIGHT: red_ahead = light_controlled && !lights_go[1];
      csrm_pkg::TURN_LEFT:     red_ahead = light_controlled && !lights_go[0];
      csrm_pkg::TURN_RIGHT:    red_ahead = light_controlled && !lights_go[2];
      default:                 red_ahead = 1'b0;
    endcase

    zone_hit = at_pedestrian || near_crossing;

    case (item.req_type)
      csrm_pkg::REQ_MAP: begin
        near_crossing_next    = item.distance_dm < cfg.cross_area_dm;
        at_pedestrian_next    = item.lane_flag == 8'd2;
        in_construction_next  = item.lane_flag == 8'd3;
        light_controlled_next = item.crossing_kind >= 8'd3;
        if (item.crossing_kind == 8'd0 || item.crossing_kind == 8'd3) begin
          turn_dir_next = csrm_pkg::TURN_STRAIGHT;
        end else if (item.crossing_kind == 8'd1 || item.crossing_kind == 8'd4) begin
          turn_dir_next = csrm_pkg::TURN_LEFT;
        end else begin
          turn_dir_next = csrm_pkg::TURN_RIGHT;
        end
      end
      csrm_pkg::REQ_SPEED: begin
        speed_now_next = item.speed_cq;
      end
      csrm_pkg::REQ_LIGHTS: begin
        lights_go_next = {item.right_color != cfg.red_code,
                          item.forward_color != cfg.red_code,
                          item.left_color != cfg.red_code};
      end
      csrm_pkg::REQ_TICK: begin
        // construction timeout saturates and is never cleared
        if (in_construction) begin
          if (construction_ticks != csrm_pkg::TICK_MAX) begin
            construction_ticks_next = construction_ticks + 16'd1;
          end
          if (construction_ticks_next > cfg.construction_limit) begin
            in_construction_next = 1'b0;
          end
        end
        if (stopped_ok && !in_construction_next) begin
          if (stop_ticks != csrm_pkg::TICK_MAX) begin
            stop_inc = stop_ticks + 16'd1;
          end
          if (stop_inc > cfg.recover_wait_ticks) begin
            stop_ticks_next = 16'd0;
            recovered_next  = 1'b1;
          end else begin
            stop_ticks_next = stop_inc;
          end
        end
      end
      csrm_pkg::REQ_DECIDE: begin
        if (zone_hit) begin
          mode_next = recovered ? csrm_pkg::MODE_FOLLOW : csrm_pkg::MODE_HOLD;
        end else begin
          recovered_next = 1'b0;
        end
        last_mode_next = mode_next;
      end
      default: ;
    endcase
  end

  assign stopped_ok = last_mode[2] && (speed_mag < {2'b00, cfg.stop_speed_cq}) &&
                      !at_pedestrian && !red_ahead;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_crossing      <= 1'b0;
      at_pedestrian      <= 1'b0;
      light_controlled   <= 1'b0;
      turn_dir           <= csrm_pkg::TURN_STRAIGHT;
      in_construction    <= 1'b0;
      construction_ticks <= 16'd0;
      stop_ticks         <= 16'd0;
      recovered          <= csrm_pkg::RST_RECOVER_INIT;
      last_mode          <= csrm_pkg::MODE_FOLLOW;
      speed_now          <= 16'sd0;
      lights_go          <= 3'b111;
    end else begin
      if (take) begin
        near_crossing      <= near_crossing_next;
        at_pedestrian      <= at_pedestrian_next;
        light_controlled   <= light_controlled_next;
        turn_dir           <= turn_dir_next;
        in_construction    <= in_construction_next;
        construction_ticks <= construction_ticks_next;
        stop_ticks         <= stop_ticks_next;
        last_mode          <= last_mode_next;
        speed_now          <= speed_now_next;
        lights_go          <= lights_go_next;
      end
      // a register write to recover_initial wins over the transaction
      if (rec_load.load) begin
        recovered <= rec_load.value;
      end else if (take) begin
        recovered <= recovered_next;
      end
    end
  end

  // recovery counter never moves above its threshold on a tick
  assert property (@(posedge clk) disable iff (rst)
    (take && item.req_type == csrm_pkg::REQ_TICK && !rec_load.load)
      |=> (stop_ticks <= cfg.recover_wait_ticks || $stable(stop_ticks)))
    else $error("stop tick counter passed its threshold");

endmodule

`default_nettype wire
